[rtl/segisp_pkg.sv]
// Package with the payload types and fixed widths of the segment intersection block.
`timescale 1ns / 1ps

package segisp_pkg;

	// Coordinate width and number of fraction bits of the crossing point.
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int OUT_BITS   = COORD_BITS + FRAC_BITS;

	// One input item: the endpoints of segment A and of segment B.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] start1_x;
		logic signed [COORD_BITS-1:0] start1_y;
		logic signed [COORD_BITS-1:0] end1_x;
		logic signed [COORD_BITS-1:0] end1_y;
		logic signed [COORD_BITS-1:0] start2_x;
		logic signed [COORD_BITS-1:0] start2_y;
		logic signed [COORD_BITS-1:0] end2_x;
		logic signed [COORD_BITS-1:0] end2_y;
	} seg_in_t;

	// One result item: hit flag and crossing point in signed fixed point.
	typedef struct packed {
		logic                       hit;
		logic signed [OUT_BITS-1:0] cross_x;
		logic signed [OUT_BITS-1:0] cross_y;
	} seg_out_t;

endpackage

[rtl/segment_intersection_point_top.sv]
// Pipelined segment intersection: crossing test and fixed-point crossing point.
`timescale 1ns / 1ps

// Segment intersection point. Each transfer on the input channel carries two
// segments; one result per item leaves on the output channel in the same order.
// The block accepts one item every clock cycle unless a full pipeline is held
// by a low out_ready. Four front stages form the differences, the products,
// the denominator and numerators, and the hit test; then one shift-subtract
// stage per quotient bit of the crossing offset (both coordinates in parallel
// lanes); then two stages for the sign fixup and rounding to nearest, ties away
// from zero. Every stage has its own valid bit and loads whenever it is empty or
// the stage after it moves, so bubbles close up while the output stalls.
// On a miss (parallel segments or a crossing outside either segment) hit is 0 and
// both coordinates are 0.
module segment_intersection_point_top
	import segisp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  seg_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output seg_out_t out_data
);

	localparam int CB  = COORD_BITS;
	localparam int DW  = CB + 1;         // coordinate differences
	localparam int PW  = 2 * CB + 3;     // products of differences
	localparam int NW  = 2 * CB + 4;     // signed denominator and numerators
	localparam int UW  = 2 * CB + 3;     // magnitudes and remainders
	localparam int RW  = UW + 1;         // remainder before reduction
	localparam int QW  = CB + FRAC_BITS; // quotient bits
	localparam int AW  = QW + 2;         // result before rounding
	localparam int DS0 = 4;              // index of the first divider stage
	localparam int NS  = QW + 6;         // total number of stages

	// Stage valid bits and per-stage load enables.
	logic [NS-1:0] vld_s;
	logic [NS:0]   en;

	always_comb begin
		en[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			en[k] = ~vld_s[k] | en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[NS-1];

	// Stage 1: coordinate differences.
	logic signed [DW-1:0] dx1_s1, dy1_s1, dx2_s1, dy2_s1, xd_s1, yd_s1;
	logic signed [CB-1:0] x1_s1, y1_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx1_s1 <= DW'(in_data.end1_x) - DW'(in_data.start1_x);
			dy1_s1 <= DW'(in_data.end1_y) - DW'(in_data.start1_y);
			dx2_s1 <= DW'(in_data.end2_x) - DW'(in_data.start2_x);
			dy2_s1 <= DW'(in_data.end2_y) - DW'(in_data.start2_y);
			xd_s1  <= DW'(in_data.start1_x) - DW'(in_data.start2_x);
			yd_s1  <= DW'(in_data.start1_y) - DW'(in_data.start2_y);
			x1_s1  <= in_data.start1_x;
			y1_s1  <= in_data.start1_y;
		end
	end

	// Stage 2: the six cross products.
	logic signed [PW-1:0] pa_s2, pb_s2, pc_s2, pd_s2, pe_s2, pf_s2;
	logic signed [DW-1:0] dx1_s2, dy1_s2;
	logic signed [CB-1:0] x1_s2, y1_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pa_s2  <= PW'(dy2_s1) * PW'(dx1_s1);
			pb_s2  <= PW'(dx2_s1) * PW'(dy1_s1);
			pc_s2  <= PW'(dx2_s1) * PW'(yd_s1);
			pd_s2  <= PW'(dy2_s1) * PW'(xd_s1);
			pe_s2  <= PW'(dx1_s1) * PW'(yd_s1);
			pf_s2  <= PW'(dy1_s1) * PW'(xd_s1);
			dx1_s2 <= dx1_s1;
			dy1_s2 <= dy1_s1;
			x1_s2  <= x1_s1;
			y1_s2  <= y1_s1;
		end
	end

	// Stage 3: denominator and the two parameter numerators.
	logic signed [NW-1:0] d_s3, na_s3, nb_s3;
	logic signed [DW-1:0] dx1_s3, dy1_s3;
	logic signed [CB-1:0] x1_s3, y1_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			d_s3   <= NW'(pa_s2) - NW'(pb_s2);
			na_s3  <= NW'(pc_s2) - NW'(pd_s2);
			nb_s3  <= NW'(pe_s2) - NW'(pf_s2);
			dx1_s3 <= dx1_s2;
			dy1_s3 <= dy1_s2;
			x1_s3  <= x1_s2;
			y1_s3  <= y1_s2;
		end
	end

	// Stage 4: normalize the denominator sign and test both parameters.
	logic signed [NW-1:0] d_abs, na_adj, nb_adj;
	logic signed [DW-1:0] dx_abs, dy_abs;
	logic                 hit_c;

	always_comb begin
		d_abs  = d_s3[NW-1] ? -d_s3 : d_s3;
		na_adj = d_s3[NW-1] ? -na_s3 : na_s3;
		nb_adj = d_s3[NW-1] ? -nb_s3 : nb_s3;
		hit_c  = (d_s3 != '0) && !na_adj[NW-1] && !nb_adj[NW-1] &&
			(na_adj <= d_abs) && (nb_adj <= d_abs);
		dx_abs = dx1_s3[DW-1] ? -dx1_s3 : dx1_s3;
		dy_abs = dy1_s3[DW-1] ? -dy1_s3 : dy1_s3;
	end

	logic [UW-1:0]        d_s4, na_s4;
	logic                 hit_s4;
	logic [CB-1:0]        mag_s4 [2];
	logic                 neg_s4 [2];
	logic signed [CB-1:0] base_s4 [2];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			d_s4       <= d_abs[UW-1:0];
			na_s4      <= na_adj[UW-1:0];
			hit_s4     <= hit_c;
			mag_s4[0]  <= dx_abs[CB-1:0];
			mag_s4[1]  <= dy_abs[CB-1:0];
			neg_s4[0]  <= dx1_s3[DW-1];
			neg_s4[1]  <= dy1_s3[DW-1];
			base_s4[0] <= x1_s3;
			base_s4[1] <= y1_s3;
		end
	end

	// Divider stages: one quotient bit of na * mag * 2^FRAC_BITS / d per stage.
	logic [QW-1:0]        q_sd    [QW][2];
	logic [UW-1:0]        r_sd    [QW][2];
	logic [CB-1:0]        mag_sd  [QW][2];
	logic                 neg_sd  [QW][2];
	logic signed [CB-1:0] base_sd [QW][2];
	logic [UW-1:0]        d_sd    [QW];
	logic [UW-1:0]        na_sd   [QW];
	logic                 hit_sd  [QW];

	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int BI = QW - 1 - j;

		logic [QW-1:0]        q_in    [2];
		logic [UW-1:0]        r_in    [2];
		logic [CB-1:0]        m_in    [2];
		logic                 n_in    [2];
		logic signed [CB-1:0] b_in    [2];
		logic [UW-1:0]        d_in, na_in;
		logic                 h_in;
		logic [1:0]           add_bit;
		logic [QW-1:0]        q_out   [2];
		logic [UW-1:0]        r_out   [2];

		// Select the previous stage's contents.
		if (j == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < 2; l++) begin
					q_in[l] = '0;
					r_in[l] = '0;
					m_in[l] = mag_s4[l];
					n_in[l] = neg_s4[l];
					b_in[l] = base_s4[l];
				end
				d_in  = d_s4;
				na_in = na_s4;
				h_in  = hit_s4;
			end
		end else begin : g_next
			always_comb begin
				for (int l = 0; l < 2; l++) begin
					q_in[l] = q_sd[j-1][l];
					r_in[l] = r_sd[j-1][l];
					m_in[l] = mag_sd[j-1][l];
					n_in[l] = neg_sd[j-1][l];
					b_in[l] = base_sd[j-1][l];
				end
				d_in  = d_sd[j-1];
				na_in = na_sd[j-1];
				h_in  = hit_sd[j-1];
			end
		end

		// The multiplier bit that this stage adds in, if any.
		if (BI >= FRAC_BITS) begin : g_add
			assign add_bit[0] = m_in[0][BI-FRAC_BITS];
			assign add_bit[1] = m_in[1][BI-FRAC_BITS];
		end else begin : g_noadd
			assign add_bit = 2'b00;
		end

		// Shift, reduce, add the numerator, reduce again.
		always_comb begin
			logic [RW-1:0] r2, r2b, r3, r4, dd;
			logic          b1, b2;
			dd = {1'b0, d_in};
			for (int l = 0; l < 2; l++) begin
				r2  = {r_in[l], 1'b0};
				b1  = (r2 >= dd);
				r2b = b1 ? r2 - dd : r2;
				r3  = r2b + (add_bit[l] ? {1'b0, na_in} : '0);
				b2  = (r3 >= dd);
				r4  = b2 ? r3 - dd : r3;
				r_out[l] = r4[UW-1:0];
				q_out[l] = {q_in[l][QW-2:0], 1'b0} + QW'(b1) + QW'(b2);
			end
		end

		always_ff @(posedge clk) begin
			if (en[DS0+j]) begin
				for (int l = 0; l < 2; l++) begin
					q_sd[j][l]    <= q_out[l];
					r_sd[j][l]    <= r_out[l];
					mag_sd[j][l]  <= m_in[l];
					neg_sd[j][l]  <= n_in[l];
					base_sd[j][l] <= b_in[l];
				end
				d_sd[j]   <= d_in;
				na_sd[j]  <= na_in;
				hit_sd[j] <= h_in;
			end
		end
	end

	// Stage 5: apply the sign of the segment direction to the quotient.
	logic signed [AW-1:0] a_c  [2];
	logic [UW-1:0]        rr_c [2];

	always_comb begin
		logic signed [AW-1:0] base_f, qx;
		for (int l = 0; l < 2; l++) begin
			base_f = AW'(base_sd[QW-1][l]) <<< FRAC_BITS;
			qx     = signed'(AW'(q_sd[QW-1][l]));
			if (!neg_sd[QW-1][l]) begin
				a_c[l]  = base_f + qx;
				rr_c[l] = r_sd[QW-1][l];
			end else if (r_sd[QW-1][l] == '0) begin
				a_c[l]  = base_f - qx;
				rr_c[l] = '0;
			end else begin
				a_c[l]  = base_f - qx - AW'(1);
				rr_c[l] = d_sd[QW-1] - r_sd[QW-1][l];
			end
		end
	end

	logic signed [AW-1:0] a_s5  [2];
	logic [UW-1:0]        rr_s5 [2];
	logic [UW-1:0]        d_s5;
	logic                 hit_s5;

	always_ff @(posedge clk) begin
		if (en[DS0+QW]) begin
			for (int l = 0; l < 2; l++) begin
				a_s5[l]  <= a_c[l];
				rr_s5[l] <= rr_c[l];
			end
			d_s5   <= d_sd[QW-1];
			hit_s5 <= hit_sd[QW-1];
		end
	end

	// Stage 6: round to nearest, ties away from zero; zero the point on a miss.
	logic [QW-1:0] res_c [2];

	always_comb begin
		logic [RW-1:0]        twice, dd;
		logic                 inc;
		logic signed [AW-1:0] sum;
		dd = {1'b0, d_s5};
		for (int l = 0; l < 2; l++) begin
			twice = {rr_s5[l], 1'b0};
			if (!a_s5[l][AW-1]) begin
				inc = (twice >= dd);
			end else begin
				inc = (rr_s5[l] != '0) && (twice > dd);
			end
			sum      = a_s5[l] + AW'(inc);
			res_c[l] = hit_s5 ? sum[QW-1:0] : '0;
		end
	end

	seg_out_t out_s6;

	always_ff @(posedge clk) begin
		if (en[DS0+QW+1]) begin
			out_s6.hit     <= hit_s5;
			out_s6.cross_x <= res_c[0];
			out_s6.cross_y <= res_c[1];
		end
	end

	assign out_data = out_s6;

endmodule
